// ===== src/four_channel_dma_controller_unit_defines.svh =====
// ---------------------------------------------------------------------------
// DMA controller assertion macros
// Shared concurrent assertion forms for the DMA controller.
// ---------------------------------------------------------------------------
`ifndef FOUR_CHANNEL_DMA_CONTROLLER_UNIT_DEFINES_SVH
`define FOUR_CHANNEL_DMA_CONTROLLER_UNIT_DEFINES_SVH

// implication checked on every clock edge outside reset
`define DMA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define DMA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/dma4_pkg.sv =====
// ---------------------------------------------------------------------------
// DMA controller package
// Beat types, function codes and address constants for the DMA controller.
// ---------------------------------------------------------------------------
package dma4_pkg;

   localparam int NumChan = 4;

   localparam logic [2:0] FUNC_WRITE  = 3'd0;
   localparam logic [2:0] FUNC_READ   = 3'd1;
   localparam logic [2:0] FUNC_TRIG   = 3'd2;
   localparam logic [2:0] FUNC_STEP   = 3'd3;
   localparam logic [2:0] FUNC_RETURN = 3'd4;

   localparam logic [2:0] OCC_HBLANK = 3'd0;
   localparam logic [2:0] OCC_VBLANK = 3'd1;
   localparam logic [2:0] OCC_VIDEO  = 3'd2;
   localparam logic [2:0] OCC_FIFO_A = 3'd3;
   localparam logic [2:0] OCC_FIFO_B = 3'd4;
   localparam logic [2:0] OCC_STOP   = 3'd5;

   localparam logic [2:0] KIND_NONE  = 3'd0;
   localparam logic [2:0] KIND_BYTE  = 3'd1;
   localparam logic [2:0] KIND_READ  = 3'd2;
   localparam logic [2:0] KIND_IDLE  = 3'd3;
   localparam logic [2:0] KIND_HALF  = 3'd4;
   localparam logic [2:0] KIND_WORD  = 3'd5;

   localparam logic [31:0] FIFO_A_ADDR   = 32'h0400_00A0;
   localparam logic [31:0] FIFO_B_ADDR   = 32'h0400_00A4;
   localparam logic [31:0] SRC_LOW_LIMIT = 32'h0200_0000;

   typedef struct packed {
      logic [2:0]  func;
      logic [1:0]  channel;
      logic [3:0]  offset;
      logic [7:0]  write_data;
      logic [2:0]  occasion;
      logic [31:0] read_data;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  reg_byte;
      logic [31:0] bus_address;
      logic [31:0] bus_data;
      logic        sequential;
      logic        irq;
      logic [1:0]  irq_channel;
      logic [2:0]  active_channel;
      logic        last;
   } rsp_type;

   // one or two result beats produced by one request
   typedef struct packed {
      rsp_type first;
      rsp_type second;
      logic    two;
   } pair_type;

   function automatic logic [2:0] lowest(input logic [3:0] m);
      logic [2:0] r;
      r = 3'd4;
      if (m[3]) r = 3'd3;
      if (m[2]) r = 3'd2;
      if (m[1]) r = 3'd1;
      if (m[0]) r = 3'd0;
      return r;
   endfunction

   function automatic logic [31:0] delta(input logic [1:0] sel);
      logic [31:0] d;
      case (sel)
         2'd0:    d = 32'd2;
         2'd1:    d = 32'hFFFF_FFFE;
         2'd2:    d = 32'd0;
         default: d = 32'd2;
      endcase
      return d;
   endfunction

endpackage

// ===== src/dma4_core.sv =====
// ---------------------------------------------------------------------------
// DMA controller core
// Channel state and combinational evaluation of one request beat.
// ---------------------------------------------------------------------------
module dma4_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  dma4_pkg::req_type req,
   output dma4_pkg::pair_type pair
);
   import dma4_pkg::*;

   logic [27:0] src_reg_ff [NumChan], src_reg_in [NumChan];
   logic [27:0] dst_reg_ff [NumChan], dst_reg_in [NumChan];
   logic [15:0] cnt_reg_ff [NumChan], cnt_reg_in [NumChan];
   logic [10:0] ctl_ff [NumChan], ctl_in [NumChan];
   logic [3:0]  fifo_ff, fifo_in;
   logic [31:0] cur_src_ff [NumChan], cur_src_in [NumChan];
   logic [31:0] cur_dst_ff [NumChan], cur_dst_in [NumChan];
   logic [16:0] cur_cnt_ff [NumChan], cur_cnt_in [NumChan];
   logic [3:0]  run_ff, run_in, hbl_ff, hbl_in, vbl_ff, vbl_in, vid_ff, vid_in;
   logic [31:0] latch_ff, latch_in;
   logic        await_ff, await_in, seq_ff, seq_in, pseq_ff, pseq_in;
   logic [1:0]  pch_ff, pch_in, lastc_ff, lastc_in;

   // evaluate one beat
   always_comb begin
      logic [1:0]  c, sc;
      logic [10:0] cb;
      logic [15:0] lmask;
      logic [16:0] rl;
      logic [3:0]  pg;
      logic [1:0]  tm;
      logic        was_on, word, s, irq, ec;
      logic [31:0] sd, dd, data, addr, m, rdl;
      logic [2:0]  sel;
      rsp_type     r0, r1;

      src_reg_in = src_reg_ff;
      dst_reg_in = dst_reg_ff;
      cnt_reg_in = cnt_reg_ff;
      ctl_in = ctl_ff;
      fifo_in = fifo_ff;
      cur_src_in = cur_src_ff;
      cur_dst_in = cur_dst_ff;
      cur_cnt_in = cur_cnt_ff;
      run_in = run_ff;
      hbl_in = hbl_ff;
      vbl_in = vbl_ff;
      vid_in = vid_ff;
      latch_in = latch_ff;
      await_in = await_ff;
      seq_in = seq_ff;
      pseq_in = pseq_ff;
      pch_in = pch_ff;
      lastc_in = lastc_ff;
      r0 = '0;
      r1 = '0;
      pair.two = 1'b0;
      c = req.channel;
      cb = ctl_ff[c];
      lmask = (c == 2'd3) ? 16'hFFFF : 16'h3FFF;
      rl = '0;
      pg = '0;
      tm = '0;
      was_on = 1'b0;
      word = 1'b0;
      s = 1'b0;
      irq = 1'b0;
      ec = 1'b0;
      sd = '0;
      dd = '0;
      data = '0;
      addr = '0;
      m = '0;
      rdl = '0;
      sc = '0;
      sel = '0;

      case (req.func)
         FUNC_WRITE: begin
            case (req.offset)
               4'd0, 4'd1, 4'd2, 4'd3: begin
                  m = {4'h0, ((c == 2'd0) ? 28'h7FF_FFFF : 28'hFFF_FFFF)};
                  addr = {4'h0, src_reg_ff[c]} & ~(32'hFF << {req.offset[1:0], 3'b000});
                  addr = addr | (({24'h0, req.write_data} << {req.offset[1:0], 3'b000}) & m);
                  src_reg_in[c] = addr[27:0];
               end
               4'd4, 4'd5, 4'd6, 4'd7: begin
                  m = {4'h0, ((c == 2'd3) ? 28'hFFF_FFFF : 28'h7FF_FFFF)};
                  addr = {4'h0, dst_reg_ff[c]} & ~(32'hFF << {req.offset[1:0], 3'b000});
                  addr = addr | (({24'h0, req.write_data} << {req.offset[1:0], 3'b000}) & m);
                  dst_reg_in[c] = addr[27:0];
               end
               4'd8: cnt_reg_in[c] = {cnt_reg_ff[c][15:8], req.write_data};
               4'd9: cnt_reg_in[c] = {req.write_data, cnt_reg_ff[c][7:0]};
               4'd10: begin
                  ctl_in[c] = {cb[10:4], cb[3], req.write_data[7], req.write_data[6:5]};
               end
               4'd11: begin
                  was_on = cb[10];
                  tm = req.write_data[5:4];
                  cb = {req.write_data[7], req.write_data[6], tm,
                        req.write_data[3] & (c == 2'd3), req.write_data[2],
                        req.write_data[1] & (tm != 2'd0), req.write_data[0], cb[2:0]};
                  hbl_in[c] = 1'b0;
                  vbl_in[c] = 1'b0;
                  vid_in[c] = 1'b0;
                  if (!cb[10]) begin
                     run_in[c] = 1'b0;
                  end else begin
                     if (tm == 2'd1) hbl_in[c] = 1'b1;
                     else if (tm == 2'd2) vbl_in[c] = 1'b1;
                     else if (tm == 2'd3 && c == 2'd3) vid_in[c] = 1'b1;
                     if (!was_on) begin
                        pg = src_reg_ff[c][27:24];
                        if (pg >= 4'h8 && pg <= 4'hD) cb[3:2] = 2'b00;
                        if (tm == 2'd3 && (c == 2'd1 || c == 2'd2)) begin
                           fifo_in[c] = 1'b1;
                           cb[5] = 1'b1;
                           cur_cnt_in[c] = 17'd4;
                           cur_src_in[c] = {4'h0, src_reg_ff[c][27:2], 2'b00};
                           cur_dst_in[c] = {4'h0, dst_reg_ff[c][27:2], 2'b00};
                        end else begin
                           m = cb[5] ? 32'hFFFF_FFFC : 32'hFFFF_FFFE;
                           fifo_in[c] = 1'b0;
                           cur_src_in[c] = {4'h0, src_reg_ff[c]} & m;
                           cur_dst_in[c] = {4'h0, dst_reg_ff[c]} & m;
                           rl = {1'b0, cnt_reg_ff[c] & lmask};
                           cur_cnt_in[c] = (rl == '0) ? {1'b0, lmask} + 17'd1 : rl;
                           if (tm == 2'd0) run_in[c] = 1'b1;
                        end
                     end
                  end
                  ctl_in[c] = cb;
               end
               default: ;
            endcase
         end
         FUNC_READ: begin
            r0.kind = KIND_BYTE;
            if (req.offset == 4'd10) r0.reg_byte = {cb[2:0], 5'b00000};
            else if (req.offset == 4'd11) r0.reg_byte = cb[10:3];
         end
         FUNC_TRIG: begin
            case (req.occasion)
               OCC_HBLANK: run_in = run_ff | hbl_ff;
               OCC_VBLANK: run_in = run_ff | vbl_ff;
               OCC_VIDEO:  run_in = run_ff | vid_ff;
               OCC_FIFO_A, OCC_FIFO_B: begin
                  addr = (req.occasion == OCC_FIFO_A) ? FIFO_A_ADDR : FIFO_B_ADDR;
                  for (int i = 1; i <= 2; i++) begin
                     if (ctl_ff[i][10] && ctl_ff[i][8:7] == 2'd3
                         && {4'h0, dst_reg_ff[i]} == addr)
                        run_in[i] = 1'b1;
                  end
               end
               OCC_STOP: begin
                  if (ctl_ff[3][10] && ctl_ff[3][8:7] == 2'd3) begin
                     ctl_in[3][10] = 1'b0;
                     run_in[3] = 1'b0;
                     vid_in[3] = 1'b0;
                  end
               end
               default: ;
            endcase
         end
         default: ;
      endcase

      // transfer step or bus read return: select channel, then complete
      sel = lowest(run_ff);
      sc = sel[1:0];
      if (req.func == FUNC_STEP && !await_ff && run_ff != 4'h0) begin
         if (cur_cnt_ff[sc] == '0) begin
            ec = 1'b1;
            r0.irq = ctl_ff[sc][9];
            r0.irq_channel = ctl_ff[sc][9] ? sc : 2'd0;
         end else begin
            s = seq_ff && lastc_ff == sc;
            lastc_in = sc;
            seq_in = 1'b1;
            r0.sequential = s;
            if (cur_src_ff[sc] >= SRC_LOW_LIMIT) begin
               r0.kind = KIND_READ;
               r0.bus_address = cur_src_ff[sc];
               await_in = 1'b1;
               pch_in = sc;
               pseq_in = s;
            end else begin
               r0.kind = KIND_IDLE;
               pair.two = 1'b1;
               rdl = latch_ff;
            end
         end
      end
      if (req.func == FUNC_RETURN && await_ff) begin
         sc = pch_ff;
         s = pseq_ff;
         await_in = 1'b0;
         rdl = (fifo_ff[sc] || ctl_ff[sc][5]) ? req.read_data
                                             : {req.read_data[15:0], req.read_data[15:0]};
         latch_in = rdl;
      end
      // element write and address update
      if (pair.two || (req.func == FUNC_RETURN && await_ff)) begin
         word = fifo_ff[sc] || ctl_ff[sc][5];
         sd = delta(ctl_ff[sc][3:2]);
         dd = fifo_ff[sc] ? 32'd0 : delta(ctl_ff[sc][1:0]);
         data = word ? rdl : {rdl[15:0], rdl[15:0]};
         if (word) begin
            sd = {sd[30:0], 1'b0};
            dd = {dd[30:0], 1'b0};
         end
         cur_src_in[sc] = cur_src_ff[sc] + sd;
         cur_dst_in[sc] = cur_dst_ff[sc] + dd;
         cur_cnt_in[sc] = (cur_cnt_ff[sc] != '0) ? cur_cnt_ff[sc] - 17'd1 : '0;
         r1.kind = word ? KIND_WORD : KIND_HALF;
         r1.bus_address = cur_dst_ff[sc];
         r1.bus_data = data;
         r1.sequential = s;
         if (cur_cnt_in[sc] == '0 && run_ff[sc]) begin
            ec = 1'b1;
            r1.irq = ctl_ff[sc][9];
            r1.irq_channel = ctl_ff[sc][9] ? sc : 2'd0;
         end
         if (!pair.two) r0 = r1;
      end
      // end of transfer: reload or disable
      if (ec) begin
         run_in[sc] = 1'b0;
         seq_in = 1'b0;
         if (ctl_ff[sc][4]) begin
            if (fifo_ff[sc]) begin
               cur_cnt_in[sc] = 17'd4;
            end else begin
               lmask = (sc == 2'd3) ? 16'hFFFF : 16'h3FFF;
               rl = {1'b0, cnt_reg_ff[sc] & lmask};
               cur_cnt_in[sc] = (rl == '0) ? {1'b0, lmask} + 17'd1 : rl;
               if (ctl_ff[sc][1:0] == 2'd3) begin
                  m = ctl_ff[sc][5] ? 32'hFFFF_FFFC : 32'hFFFF_FFFE;
                  cur_dst_in[sc] = {4'h0, dst_reg_ff[sc]} & m;
               end
            end
         end else begin
            ctl_in[sc][10] = 1'b0;
            hbl_in[sc] = 1'b0;
            vbl_in[sc] = 1'b0;
            vid_in[sc] = 1'b0;
         end
      end
      r0.active_channel = lowest(run_in);
      r1.active_channel = lowest(run_in);
      r0.last = !pair.two;
      r1.last = 1'b1;
      pair.first = r0;
      pair.second = r1;
   end

   // hold channel state, advance on an accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NumChan; i++) begin
            src_reg_ff[i] <= '0;
            dst_reg_ff[i] <= '0;
            cnt_reg_ff[i] <= '0;
            ctl_ff[i] <= '0;
            cur_src_ff[i] <= '0;
            cur_dst_ff[i] <= '0;
            cur_cnt_ff[i] <= '0;
         end
         fifo_ff <= '0;
         run_ff <= '0;
         hbl_ff <= '0;
         vbl_ff <= '0;
         vid_ff <= '0;
         latch_ff <= '0;
         await_ff <= 1'b0;
         seq_ff <= 1'b0;
         pseq_ff <= 1'b0;
         pch_ff <= '0;
         lastc_ff <= '0;
      end else if (take) begin
         src_reg_ff <= src_reg_in;
         dst_reg_ff <= dst_reg_in;
         cnt_reg_ff <= cnt_reg_in;
         ctl_ff <= ctl_in;
         cur_src_ff <= cur_src_in;
         cur_dst_ff <= cur_dst_in;
         cur_cnt_ff <= cur_cnt_in;
         fifo_ff <= fifo_in;
         run_ff <= run_in;
         hbl_ff <= hbl_in;
         vbl_ff <= vbl_in;
         vid_ff <= vid_in;
         latch_ff <= latch_in;
         await_ff <= await_in;
         seq_ff <= seq_in;
         pseq_ff <= pseq_in;
         pch_ff <= pch_in;
         lastc_ff <= lastc_in;
      end
   end

endmodule

// ===== src/dma4_out_queue.sv =====
// ---------------------------------------------------------------------------
// DMA controller result queue
// Four-entry queue of result beats; admits pairs while two slots are free.
// ---------------------------------------------------------------------------
module dma4_out_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  dma4_pkg::pair_type pair,
   output logic               room,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output dma4_pkg::rsp_type  rsp_data
);
   import dma4_pkg::*;

   rsp_type    buf_ff [4];
   logic [1:0] rd_ff, rd_in, wr_ff, wr_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       pop;

   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_valid = cnt_ff != 3'd0;
   assign rsp_data  = buf_ff[rd_ff];
   assign room      = cnt_ff <= 3'd2;

   // advance pointers and count
   always_comb begin
      rd_in = rd_ff + {1'b0, pop};
      wr_in = wr_ff + (push ? (pair.two ? 2'd2 : 2'd1) : 2'd0);
      cnt_in = cnt_ff - {2'b00, pop} + (push ? (pair.two ? 3'd2 : 3'd1) : 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff <= '0;
         wr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         rd_ff <= rd_in;
         wr_ff <= wr_in;
         cnt_ff <= cnt_in;
      end
   end

   // store result beats
   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ff] <= pair.first;
         if (pair.two) buf_ff[wr_ff + 2'd1] <= pair.second;
      end
   end

endmodule

// ===== src/four_channel_dma_controller_unit.sv =====
// Each taken beat is queued, so rsp_valid is high the cycle after; older queued results leave first.
// Throughput: one request beat per cycle while the queue has room; a step with an idle
// source yields two result beats, so sustained output limits input to one beat per
// result beat. The four-entry result queue sets the stall on the request side.
// Reset: synchronous, active high; clears all channel state and the queue.
// ---------------------------------------------------------------------------
// Four-channel DMA controller top level
// Channel core feeding a result queue over valid/stall channels.
// ---------------------------------------------------------------------------
`include "four_channel_dma_controller_unit_defines.svh"

module four_channel_dma_controller_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dma4_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dma4_pkg::rsp_type rsp_data
);
   import dma4_pkg::*;

   pair_type pair;
   logic     room, take;

   assign req_stall = !room;
   assign take      = req_valid && room;

   dma4_core u_core (
      .clock(clock),
      .reset(reset),
      .take (take),
      .req  (req_data),
      .pair (pair)
   );

   dma4_out_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (take),
      .pair     (pair),
      .room     (room),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   `DMA_ASSERT_NEXT(a_take_valid, clock, reset, take, rsp_valid, "no result after request")
   `DMA_ASSERT_IMP(a_act_range, clock, reset, rsp_valid, rsp_data.active_channel <= 3'd4, "bad channel")
   `DMA_ASSERT_IMP(a_irq_ch, clock, reset, rsp_valid && !rsp_data.irq, rsp_data.irq_channel == 2'd0, "irq channel without irq")

endmodule
